>>> rtl/core/pbd_pkg.sv
package pbd_pkg;

  localparam int INDEX_BITS = 24;
  localparam int POS_W      = INDEX_BITS + 1;
  localparam int LEN_W      = 8;
  localparam int CFG_W      = 25;

  localparam logic [POS_W-1:0] PLANE_CAP = POS_W'(1) << INDEX_BITS;

  // decode phase codes
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_RUN     = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;
  localparam logic [1:0] PH_DROP    = 2'd3;

  // header byte that is skipped
  localparam logic [7:0] HDR_SKIP = 8'd128;

  // register indexes
  localparam logic CFG_PLANE_PIXELS = 1'b0;
  localparam logic CFG_CHANNEL      = 1'b1;

  // channel select codes
  localparam logic [2:0] CH_RED     = 3'd0;
  localparam logic [2:0] CH_GREEN   = 3'd1;
  localparam logic [2:0] CH_BLUE    = 3'd2;
  localparam logic [2:0] CH_ALPHA   = 3'd3;
  localparam logic [2:0] CH_DISCARD = 3'd4;

  // byte lanes of the packed pixel word
  localparam logic [1:0] LANE_BLUE  = 2'd0;
  localparam logic [1:0] LANE_GREEN = 2'd1;
  localparam logic [1:0] LANE_RED   = 2'd2;
  localparam logic [1:0] LANE_ALPHA = 2'd3;

  typedef struct packed {
    logic [INDEX_BITS-1:0] start_index;
    logic [7:0]            pixel_value;
    logic [LEN_W-1:0]      run_length;
    logic [1:0]            byte_lane;
    logic                  write_enable;
    logic                  plane_done;
  } pbd_result_t;

endpackage

>>> rtl/core/pbd_decode.sv
module pbd_decode (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [pbd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_fire,
  input  logic [7:0]               in_byte,
  output logic                     res_valid,
  output pbd_pkg::pbd_result_t     res
);
  import pbd_pkg::*;

  logic [POS_W-1:0]      plane_pixels_r;
  logic [2:0]            channel_r;
  logic [1:0]            phase_r, phase_nxt;
  logic [LEN_W-1:0]      pending_r, pending_nxt;
  logic [INDEX_BITS-1:0] pos_r, pos_nxt;

  logic [POS_W-1:0]      lim;
  logic [INDEX_BITS-1:0] pos_base;
  logic [POS_W-1:0]      left;
  logic [LEN_W-1:0]      req_len;
  logic [LEN_W-1:0]      len;
  logic [POS_W-1:0]      pos_sum;
  logic                  done;
  logic                  emit;
  logic [LEN_W-1:0]      pending_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_pixels_r <= POS_W'(1);
      channel_r      <= CH_RED;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PLANE_PIXELS: plane_pixels_r <= cfg_wdata[POS_W-1:0];
        CFG_CHANNEL:      channel_r      <= cfg_wdata[2:0];
        default:          ;
      endcase
    end
  end

  // effective plane size: zero acts as one, capped at the index range
  always_comb begin
    if (plane_pixels_r == '0)
      lim = POS_W'(1);
    else if (plane_pixels_r > PLANE_CAP)
      lim = PLANE_CAP;
    else
      lim = plane_pixels_r;
  end

  always_comb begin
    pos_base = ({1'b0, pos_r} >= lim) ? '0 : pos_r;
    left     = lim - {1'b0, pos_base};
    req_len  = (phase_r == PH_RUN) ? pending_r : LEN_W'(1);
    len      = ({{(POS_W-LEN_W){1'b0}}, req_len} > left) ? left[LEN_W-1:0] : req_len;
    pos_sum  = {1'b0, pos_base} + {{(POS_W-LEN_W){1'b0}}, len};
    done     = (pos_sum >= lim);
    pending_dec = pending_r - LEN_W'(1);
  end

  always_comb begin
    res.start_index  = pos_base;
    res.run_length   = len;
    res.plane_done   = done;
    res.pixel_value  = in_byte;
    res.write_enable = 1'b1;
    case (channel_r)
      CH_RED:   res.byte_lane = LANE_RED;
      CH_GREEN: res.byte_lane = LANE_GREEN;
      CH_BLUE:  res.byte_lane = LANE_BLUE;
      CH_ALPHA: begin
        res.byte_lane   = LANE_ALPHA;
        res.pixel_value = ~in_byte;
      end
      default: begin
        res.byte_lane    = LANE_BLUE;
        res.write_enable = 1'b0;
      end
    endcase
  end

  assign emit      = (phase_r == PH_RUN) || (phase_r == PH_LITERAL);
  assign res_valid = in_fire && emit;

  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    pos_nxt     = pos_r;
    case (phase_r)
      PH_HEADER: begin
        if (in_byte < HDR_SKIP) begin
          phase_nxt   = PH_LITERAL;
          pending_nxt = in_byte + LEN_W'(1);
        end else if (in_byte > HDR_SKIP) begin
          phase_nxt   = PH_RUN;
          pending_nxt = LEN_W'(9'd257 - {1'b0, in_byte});
        end
      end
      PH_RUN: begin
        phase_nxt   = PH_HEADER;
        pending_nxt = '0;
        pos_nxt     = done ? '0 : pos_sum[INDEX_BITS-1:0];
      end
      PH_LITERAL: begin
        pending_nxt = pending_dec;
        pos_nxt     = done ? '0 : pos_sum[INDEX_BITS-1:0];
        if (pending_dec == '0)
          phase_nxt = PH_HEADER;
        else if (done)
          phase_nxt = PH_DROP; // rest of literal falls past plane end
      end
      default: begin
        pending_nxt = pending_dec;
        if (pending_dec == '0)
          phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pending_r <= '0;
      pos_r     <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

>>> rtl/core/pbd_out_reg.sv
module pbd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  pbd_pkg::pbd_result_t res,
  output logic                 slot_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pbd_pkg::pbd_result_t out_res
);
  import pbd_pkg::*;

  logic        valid_r, valid_nxt;
  pbd_result_t data_r;

  // slot frees in the same cycle the held beat is taken
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free)
      valid_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else
      valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid)
      data_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

>>> rtl/core/packbits_plane_decoder_unit.sv
// PackBits plane decoder: takes one compressed byte per beat and turns headers,
// run values and literal bytes into pixel writes (start index, value, length,
// byte lane). A byte is accepted every cycle while the result register is
// empty or being drained; a write appears on the output in the cycle after the
// byte that caused it, and header or dropped bytes give no output beat. The
// only stall source is the single output register: when a result is held and
// out_tready is low, in_tready drops. Configure plane_pixels and
// channel_select only while no beat is in flight.
module packbits_plane_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [pbd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] in_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [39:0]               out_tdata,  // [23:0] start_index, [31:24] pixel_value,
                                                // [39:32] run_length
  output logic [2:0]                out_tuser,  // [1:0] byte_lane, [2] write_enable
  output logic                      out_tlast   // plane_done
);
  import pbd_pkg::*;

  logic        slot_free;
  logic        in_fire;
  logic        res_valid;
  pbd_result_t res;
  pbd_result_t out_res;

  assign in_tready = slot_free;
  assign in_fire   = in_tvalid && slot_free;

  pbd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  pbd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.run_length, out_res.pixel_value, out_res.start_index};
  assign out_tuser = {out_res.write_enable, out_res.byte_lane};
  assign out_tlast = out_res.plane_done;

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.run_length != '0) && (out_res.run_length <= LEN_W'(128)))
    else $error("run_length out of range");

  a_discard_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_res.write_enable) |-> (out_res.byte_lane == LANE_BLUE))
    else $error("discarded write carries a nonzero lane");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_fit_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_res.start_index} + POS_W'(out_res.run_length)) <= PLANE_CAP)
    else $error("write runs past the index range");

endmodule
